// ===== sv/rmpi_pkg.sv =====
// Package for the recursive mutex manager: command, status and state codes.
// Used by the top level and the checker; no dependencies of its own.
package rmpi_pkg;

   // Command codes carried on req_mode.
   localparam logic [1:0] MODE_CREATE  = 2'd0;
   localparam logic [1:0] MODE_DESTROY = 2'd1;
   localparam logic [1:0] MODE_LOCK    = 2'd2;
   localparam logic [1:0] MODE_UNLOCK  = 2'd3;

   // Status codes returned on rsp_status.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ID    = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   // Largest recursive lock depth.
   localparam logic [7:0] DEPTH_MAX = 8'd255;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

endpackage

// ===== sv/rmpi_waitq.sv =====
// Waiter queue memory: pid and priority of every queued waiter, per slot.
// Depends on nothing; one write port and one registered read port.
module rmpi_waitq #(
   parameter int AW = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [2**AW];
   logic [7:0] rd_data_ff;

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/recursive_mutex_priority_inherit_top.sv =====
// Recursive mutex manager with priority inheritance, top level.
// The slot record and waiter head are read at the transfer edge; the update is written
// in the S_READ state, where the response registers are also loaded.
// Commands are handled one at a time; a new request is taken only after the response is
// accepted. Reset (synchronous, active high) frees all slots and clears the id counter.
// Depends on rmpi_pkg and rmpi_waitq.
module recursive_mutex_priority_inherit_top #(
   parameter int MAX_MUTEXES = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int LOWEST_PRIO = 15,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_mutex_id,
   input  logic [3:0]  req_pid,
   input  logic [3:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_new_id,
   output logic [3:0]  rsp_caller_priority,
   output logic        rsp_caller_waits,
   output logic        rsp_switch_request,
   output logic        rsp_woken_valid,
   output logic [3:0]  rsp_woken_pid,
   output logic [3:0]  rsp_woken_priority
);
   localparam int SW = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int UW = $clog2(MAX_MUTEXES + 1);
   localparam int AW = SW + QW;
   localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};
   localparam logic [3:0] LOW_P = 4'(LOWEST_PRIO);

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [3:0]         owner;
      logic [7:0]         depth;
      logic [3:0]         base;
      logic [3:0]         top;
      logic [QW-1:0]      head;
      logic [QW-1:0]      tail;
      logic [CW-1:0]      count;
   } slot_type;

   // Slot record memory and valid bits (valid bits need a reset).
   slot_type            slot_mem [MAX_MUTEXES];
   logic [MAX_MUTEXES-1:0] valid_ff;
   logic [UW-1:0]       used_ff;
   logic [ID_BITS-1:0]  last_id_ff;
   logic [1:0]          state_ff;

   // Captured request.
   logic [1:0]  mode_ff;
   logic [15:0] id_ff;
   logic [3:0]  pid_ff, pri_ff;

   // Slot search result, registered with the read.
   logic [SW-1:0] hit_in, hit_ff, free_in, free_ff;
   logic          found_in, found_ff, has_free_in, has_free_ff;
   slot_type      rec_ff;

   // Response registers.
   logic        rsp_valid_ff;
   logic [2:0]  status_ff;
   logic [15:0] new_id_ff;
   logic [3:0]  cpri_ff, wpid_ff, wpri_ff;
   logic        waits_ff, sw_ff, wv_ff;

   logic req_xfer;
   assign req_stall = (state_ff != rmpi_pkg::S_IDLE) | rsp_valid_ff;
   assign req_xfer  = req_valid & ~req_stall;

   // Match the requested id and find the lowest free slot.
   always_comb begin
      hit_in = '0; found_in = 1'b0; free_in = '0; has_free_in = 1'b0;
      for (int s = MAX_MUTEXES - 1; s >= 0; s--) begin
         if (valid_ff[s] && req_mutex_id == 16'(slot_mem[s].id)) begin
            hit_in = SW'(s); found_in = 1'b1;
         end
         if (!valid_ff[s]) begin
            free_in = SW'(s); has_free_in = 1'b1;
         end
      end
   end

   // Waiter memory: read the head of the hit slot, write at its tail.
   logic          wq_we;
   logic [AW-1:0] wq_waddr, wq_raddr;
   logic [7:0]    wq_rdata;
   assign wq_raddr = {hit_in, slot_mem[hit_in].head};

   rmpi_waitq #(.AW(AW)) u_waitq (
      .clock(clock), .wr_en(wq_we), .wr_addr(wq_waddr),
      .wr_data({pid_ff, pri_ff}), .rd_addr(wq_raddr), .rd_data(wq_rdata)
   );

   // Command evaluation on the registered slot record.
   slot_type      nrec;
   logic          rec_we, set_valid, clr_valid;
   logic [2:0]    st;
   logic [15:0]   nid;
   logic [3:0]    cpri, wpid, wpri;
   logic          waits, sw, wv;
   logic [SW-1:0] tgt;
   always_comb begin
      nrec = rec_ff; rec_we = 1'b0; set_valid = 1'b0; clr_valid = 1'b0;
      st = rmpi_pkg::ST_OK; nid = '0; cpri = pri_ff; wpid = '0; wpri = '0;
      waits = 1'b0; sw = 1'b0; wv = 1'b0; tgt = hit_ff; wq_we = 1'b0;
      wq_waddr = {hit_ff, rec_ff.tail};
      case (mode_ff)
         rmpi_pkg::MODE_CREATE: begin
            tgt = free_ff;
            if (used_ff >= UW'(MAX_MUTEXES) || !has_free_ff) begin
               st = rmpi_pkg::ST_FULL;
            end else if (last_id_ff >= ID_MAX) begin
               st = rmpi_pkg::ST_OVERFLOW;
            end else begin
               nrec.id = last_id_ff + 1'b1; nrec.owner = '0; nrec.depth = '0;
               nrec.base = LOW_P; nrec.top = LOW_P; nrec.head = '0;
               nrec.tail = '0; nrec.count = '0;
               rec_we = 1'b1; set_valid = 1'b1;
               nid = 16'(nrec.id);
            end
         end
         rmpi_pkg::MODE_DESTROY: begin
            if (!found_ff) st = rmpi_pkg::ST_NOT_FOUND;
            else clr_valid = 1'b1;
         end
         default: begin
            if (id_ff == '0 || pid_ff == '0) begin
               st = rmpi_pkg::ST_BAD_ID;
            end else if (!found_ff) begin
               st = rmpi_pkg::ST_NOT_FOUND;
            end else if (mode_ff == rmpi_pkg::MODE_LOCK) begin
               if (rec_ff.owner == '0) begin
                  nrec.owner = pid_ff; nrec.base = pri_ff; nrec.top = pri_ff;
                  nrec.depth = 8'd1; rec_we = 1'b1;
               end else if (rec_ff.owner == pid_ff) begin
                  if (rec_ff.depth >= rmpi_pkg::DEPTH_MAX) begin
                     st = rmpi_pkg::ST_OVERFLOW;
                  end else begin
                     nrec.depth = rec_ff.depth + 8'd1; rec_we = 1'b1;
                  end
               end else if (rec_ff.count >= CW'(QUEUE_DEPTH)) begin
                  st = rmpi_pkg::ST_OVERFLOW;
               end else begin
                  wq_we = 1'b1;
                  nrec.tail = (rec_ff.tail == QW'(QUEUE_DEPTH - 1)) ? '0
                              : rec_ff.tail + 1'b1;
                  nrec.count = rec_ff.count + 1'b1;
                  if (rec_ff.top < pri_ff) cpri = rec_ff.top;
                  else if (pri_ff < rec_ff.top) nrec.top = pri_ff;
                  waits = 1'b1; sw = 1'b1; rec_we = 1'b1;
               end
            end else begin
               if (rec_ff.owner != pid_ff) begin
                  st = rmpi_pkg::ST_NOT_FOUND;
               end else if (rec_ff.depth > 8'd1) begin
                  nrec.depth = rec_ff.depth - 8'd1; rec_we = 1'b1;
               end else begin
                  cpri = rec_ff.base; nrec.depth = '0; rec_we = 1'b1;
                  if (rec_ff.count == '0) begin
                     nrec.owner = '0;
                  end else begin
                     nrec.owner = wq_rdata[7:4]; nrec.base = wq_rdata[3:0];
                     nrec.depth = 8'd1;
                     nrec.head = (rec_ff.head == QW'(QUEUE_DEPTH - 1)) ? '0
                                 : rec_ff.head + 1'b1;
                     nrec.count = rec_ff.count - 1'b1;
                     wv = 1'b1; wpid = wq_rdata[7:4]; wpri = rec_ff.top; sw = 1'b1;
                  end
               end
            end
         end
      endcase
      if (state_ff != rmpi_pkg::S_READ) begin
         rec_we = 1'b0; wq_we = 1'b0; set_valid = 1'b0; clr_valid = 1'b0;
      end
   end

   // Slot record memory writes.
   always_ff @(posedge clock) begin
      if (rec_we) slot_mem[tgt] <= nrec;
   end

   // Request capture, registered reads and response registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff <= req_mode; id_ff <= req_mutex_id;
         pid_ff <= req_pid; pri_ff <= req_priority_req;
         hit_ff <= hit_in; found_ff <= found_in;
         free_ff <= free_in; has_free_ff <= has_free_in;
         rec_ff <= slot_mem[hit_in];
      end
      if (state_ff == rmpi_pkg::S_READ) begin
         status_ff <= st; new_id_ff <= nid; cpri_ff <= cpri;
         waits_ff <= waits; sw_ff <= sw; wv_ff <= wv;
         wpid_ff <= wpid; wpri_ff <= wpri;
      end
   end

   // Control state: sequencer, valid bits, counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmpi_pkg::S_IDLE; valid_ff <= '0; used_ff <= '0;
         last_id_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (set_valid) begin
            valid_ff[tgt] <= 1'b1; used_ff <= used_ff + 1'b1;
            last_id_ff <= last_id_ff + 1'b1;
         end
         if (clr_valid) begin
            valid_ff[tgt] <= 1'b0;
            if (used_ff != '0) used_ff <= used_ff - 1'b1;
         end
         case (state_ff)
            rmpi_pkg::S_IDLE: if (req_xfer) state_ff <= rmpi_pkg::S_READ;
            rmpi_pkg::S_READ: begin
               state_ff <= rmpi_pkg::S_DONE; rsp_valid_ff <= 1'b1;
            end
            rmpi_pkg::S_DONE: if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0; state_ff <= rmpi_pkg::S_IDLE;
            end
            default: state_ff <= rmpi_pkg::S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_new_id          = new_id_ff;
   assign rsp_caller_priority = cpri_ff;
   assign rsp_caller_waits    = waits_ff;
   assign rsp_switch_request  = sw_ff;
   assign rsp_woken_valid     = wv_ff;
   assign rsp_woken_pid       = wpid_ff;
   assign rsp_woken_priority  = wpri_ff;
endmodule

// ===== sv/rmpi_checker.sv =====
// Port-level checks for the recursive mutex manager.
// Depends on rmpi_pkg; bound to recursive_mutex_priority_inherit_top below.
module rmpi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_new_id,
   input logic        rsp_caller_waits,
   input logic        rsp_switch_request,
   input logic        rsp_woken_valid
);
   // A stalled response keeps its status.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   // Waiting or waking always asks for a switch.
   a_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_caller_waits || rsp_woken_valid) |-> rsp_switch_request)
      else $error("switch request missing");

   // A failed command issues no id, wakes nobody and does not make the caller wait.
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rmpi_pkg::ST_OK |->
         rsp_new_id == '0 && !rsp_woken_valid && !rsp_caller_waits)
      else $error("failed command had side results");

   // No new request is taken while a response is pending.
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with response pending");
endmodule

bind recursive_mutex_priority_inherit_top rmpi_checker u_rmpi_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_new_id(rsp_new_id), .rsp_caller_waits(rsp_caller_waits),
   .rsp_switch_request(rsp_switch_request), .rsp_woken_valid(rsp_woken_valid)
);
